>>> hdl/tkc_pkg.sv
`timescale 1ns / 1ps
package tkc_pkg;

    localparam int VERTEX_COUNT     = 4096;
    localparam int SLOTS_PER_VERTEX = 4;
    localparam int VTX_W            = 12;
    localparam int WORD_W           = 16;
    localparam int TOTAL_W          = 19;
    localparam int DIVD_W           = 28;
    localparam int REM_W            = 44;
    localparam int ROW_W            = SLOTS_PER_VERTEX * (2 * WORD_W + 1);

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_EMIT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [VTX_W-1:0]  vertex;
        logic [WORD_W-1:0] deformer;
        logic [WORD_W-1:0] weight;
    } req_t;

    typedef struct packed {
        logic [SLOTS_PER_VERTEX-1:0]             written;
        logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] dfm;
        logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] wt;
    } row_t;

    typedef struct packed {
        logic [VTX_W-1:0]                        vertex;
        logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] dfm;
        logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] wt;
    } result_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_DONE
    } back_state_t;

endpackage

>>> hdl/tkc_ram.sv
`timescale 1ns / 1ps
module tkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/tkc_front.sv
`timescale 1ns / 1ps
module tkc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tkc_pkg::req_t push_req,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output tkc_pkg::req_t head
);
    import tkc_pkg::*;

    // two-entry request queue
    req_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> hdl/tkc_back.sv
`timescale 1ns / 1ps
module tkc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tkc_pkg::WORD_W-1:0]    root_deformer,
    input  logic                          req_empty,
    input  tkc_pkg::req_t                 req_head,
    output logic                          req_pop,
    output logic                          clearing,
    output logic                          res_valid,
    input  logic                          res_pop,
    output tkc_pkg::result_t              res
);
    import tkc_pkg::*;

    localparam logic [25:0] NORM_SCALE = 26'd65535000;
    localparam logic [8:0]  BIAS_NUM   = 9'd499;
    localparam logic [9:0]  BIAS_DEN   = 10'd1000;

    back_state_t state_reg, state_next;

    logic [VTX_W-1:0]  clr_reg;
    req_t              req_reg;
    logic [1:0]        slot_reg;
    logic [3:0]        bit_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dsh_reg;
    logic [WORD_W-1:0] q_reg;
    logic [DIVD_W-1:0] div_reg;
    logic [DIVD_W-1:0] t499_reg;
    logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] wt_reg;
    logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] nw_reg;
    logic [VTX_W-1:0]  nvtx_reg;
    logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] ndfm_reg;
    result_t           res_reg;
    logic              res_valid_reg;

    logic              ram_we;
    logic [VTX_W-1:0]  ram_waddr;
    row_t              ram_wdata;
    logic              ram_re;
    row_t              ram_rdata;

    row_t              add_row;
    logic              add_wr;
    logic [TOTAL_W-1:0] total;
    logic              load_out;
    logic              rem_ge;
    logic [WORD_W-1:0] q_next;

    tkc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(VERTEX_COUNT)
    ) u_row_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(req_head.vertex),
        .rdata(ram_rdata)
    );

    // add: first zero slot, else lowest slot when the new weight beats it
    always_comb
    begin
        logic              found;
        logic [1:0]        sel;
        logic [1:0]        low_sel;
        logic [WORD_W:0]   low_w;
        found   = 1'b0;
        sel     = 2'd0;
        low_sel = 2'd0;
        low_w   = {1'b1, {WORD_W{1'b0}}};
        for (int k = 0; k < SLOTS_PER_VERTEX; k++)
        begin
            if (!found && ram_rdata.wt[k] == '0)
            begin
                found = 1'b1;
                sel   = 2'(k);
            end
            if ({1'b0, ram_rdata.wt[k]} < low_w)
            begin
                low_w   = {1'b0, ram_rdata.wt[k]};
                low_sel = 2'(k);
            end
        end
        if (!found)
        begin
            sel = low_sel;
        end
        add_wr  = found || ({1'b0, req_reg.weight} > low_w);
        add_row = ram_rdata;
        add_row.wt[sel]      = req_reg.weight;
        add_row.dfm[sel]     = req_reg.deformer;
        add_row.written[sel] = 1'b1;
    end

    assign total = TOTAL_W'(ram_rdata.wt[0]) + TOTAL_W'(ram_rdata.wt[1])
                 + TOTAL_W'(ram_rdata.wt[2]) + TOTAL_W'(ram_rdata.wt[3]);

    assign rem_ge = (rem_reg >= dsh_reg);
    assign q_next = q_reg | (rem_ge ? (WORD_W'(1) << bit_reg) : '0);
    assign load_out = (state_reg == S_DONE) && (!res_valid_reg || res_pop);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == VTX_W'(VERTEX_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!req_empty)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (req_reg.req_type == REQ_ADD)
                begin
                    state_next = S_IDLE;
                end
                else if (total == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (bit_reg == 4'd0)
                begin
                    state_next = (slot_reg == 2'(SLOTS_PER_VERTEX - 1)) ? S_DONE : S_PREP;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = req_reg.vertex;
        ram_wdata = add_row;
        ram_re    = 1'b0;
        req_pop   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                ram_re  = !req_empty;
                req_pop = !req_empty;
            end
            S_LOAD:
            begin
                if (req_reg.req_type == REQ_ADD)
                begin
                    ram_we = add_wr;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg <= req_head;
            end
            S_LOAD:
            begin
                wt_reg   <= ram_rdata.wt;
                div_reg  <= DIVD_W'(total) * DIVD_W'(BIAS_DEN);
                t499_reg <= DIVD_W'(total) * DIVD_W'(BIAS_NUM);
                slot_reg <= 2'd0;
                // staged apart from res_reg, which may still hold the previous result
                nvtx_reg <= req_reg.vertex;
                for (int k = 0; k < SLOTS_PER_VERTEX; k++)
                begin
                    ndfm_reg[k] <= ram_rdata.written[k] ? ram_rdata.dfm[k] : root_deformer;
                    nw_reg[k]   <= (k == 0) ? {WORD_W{1'b1}} : '0;
                end
            end
            S_PREP:
            begin
                rem_reg <= REM_W'(NORM_SCALE) * REM_W'(wt_reg[slot_reg]) + REM_W'(t499_reg);
                dsh_reg <= REM_W'(div_reg) << 15;
                bit_reg <= 4'd15;
                q_reg   <= '0;
            end
            S_DIV:
            begin
                if (rem_ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_next;
                bit_reg <= bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    nw_reg[slot_reg] <= q_next;
                    slot_reg         <= slot_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    res_reg.vertex <= nvtx_reg;
                    res_reg.dfm    <= ndfm_reg;
                    res_reg.wt     <= nw_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + VTX_W'(1);
            end
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> hdl/top_k_skin_weight_compactor.sv
`timescale 1ns / 1ps
// Top-4 skin weight compactor.
// Input channel (push/full): one request per accepted edge (push && !full).
//   req_type 0 adds an influence to a vertex, req_type 1 emits the vertex.
// Result channel (empty/pop): one result per emit request, in request order;
//   the result is on the ports while empty is low and leaves on pop && !empty.
// Config: cfg_we writes cfg_wdata into root_deformer at once; write it only
//   while the block is idle.
// A two-entry request queue sits in front of the engine, so up to two
//   requests wait while the engine works or a result waits to be taken.
// Engine steps, one request at a time, set by its sequencer and row RAM:
//   add  : pop the request and read the row, then write the updated row.
//   emit : pop the request and read the row, then write it to zero; a
//          zero-weight vertex goes straight to the result register, else
//          one 16-step restoring divide per slot, then the result register.
// A held result stalls the engine once the next emit reaches its last step;
//   the queue then fills and full stays high until pop takes the result.
// Reset: a clearing pass writes zero to all 4096 rows, one a cycle, so full
//   stays high until the pass is through. root_deformer resets to 0.
module top_k_skin_weight_compactor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [11:0] vertex_index,
    input  logic [15:0] deformer_index,
    input  logic [15:0] influence_weight,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] out_vertex,
    output logic [15:0] slot0_deformer,
    output logic [15:0] slot1_deformer,
    output logic [15:0] slot2_deformer,
    output logic [15:0] slot3_deformer,
    output logic [15:0] slot0_weight,
    output logic [15:0] slot1_weight,
    output logic [15:0] slot2_weight,
    output logic [15:0] slot3_weight
);
    import tkc_pkg::*;

    logic [WORD_W-1:0] root_deformer_reg;
    req_t              in_req;
    req_t              head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              clearing;
    logic              res_valid;
    result_t           res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_deformer_reg <= '0;
        end
        else if (cfg_we)
        begin
            root_deformer_reg <= cfg_wdata;
        end
    end

    assign in_req = '{req_type: req_type, vertex: vertex_index,
                      deformer: deformer_index, weight: influence_weight};

    // no request is taken while the row store is being cleared
    assign full = q_full || clearing;

    tkc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && !clearing),
        .push_req(in_req),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (head)
    );

    tkc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .root_deformer(root_deformer_reg),
        .req_empty    (q_empty),
        .req_head     (head),
        .req_pop      (q_pop),
        .clearing     (clearing),
        .res_valid    (res_valid),
        .res_pop      (pop),
        .res          (res)
    );

    assign empty          = !res_valid;
    assign out_vertex     = res.vertex;
    assign slot0_deformer = res.dfm[0];
    assign slot1_deformer = res.dfm[1];
    assign slot2_deformer = res.dfm[2];
    assign slot3_deformer = res.dfm[3];
    assign slot0_weight   = res.wt[0];
    assign slot1_weight   = res.wt[1];
    assign slot2_weight   = res.wt[2];
    assign slot3_weight   = res.wt[3];

endmodule

>>> sim/tkc_checker.sv
`timescale 1ns / 1ps
module tkc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    input  logic        full,
    input  logic        req_type,
    input  logic [11:0] vertex_index,
    input  logic [15:0] deformer_index,
    input  logic [15:0] influence_weight,
    input  logic        empty,
    input  logic        pop,
    input  logic [11:0] out_vertex,
    input  logic [15:0] slot0_deformer,
    input  logic [15:0] slot1_deformer,
    input  logic [15:0] slot2_deformer,
    input  logic [15:0] slot3_deformer,
    input  logic [15:0] slot0_weight,
    input  logic [15:0] slot1_weight,
    input  logic [15:0] slot2_weight,
    input  logic [15:0] slot3_weight,
    output int          fail_count,
    output int          pending_emits,
    output int          emits_seen
);
    import tkc_pkg::*;

    logic [15:0] wt_mem [VERTEX_COUNT*SLOTS_PER_VERTEX];
    logic [15:0] dfm_mem [VERTEX_COUNT*SLOTS_PER_VERTEX];
    logic        wr_mem [VERTEX_COUNT*SLOTS_PER_VERTEX];
    logic [15:0] root_dfm;
    result_t     emit_queue [$];

    // slot placement: first zero weight, else replace strict-lowest if heavier
    task automatic add_influence(input int vtx, input logic [15:0] dfm,
                                 input logic [15:0] w);
        int base;
        int low_slot;
        int low_w;
        base = vtx * SLOTS_PER_VERTEX;
        low_slot = 0;
        low_w = 32'h10000;
        for (int k = 0; k < SLOTS_PER_VERTEX; k++)
        begin
            if (wt_mem[base+k] == 0)
            begin
                wt_mem[base+k] = w;
                dfm_mem[base+k] = dfm;
                wr_mem[base+k] = 1'b1;
                return;
            end
            if (wt_mem[base+k] < low_w)
            begin
                low_w = wt_mem[base+k];
                low_slot = k;
            end
        end
        if (w > low_w)
        begin
            wt_mem[base+low_slot] = w;
            dfm_mem[base+low_slot] = dfm;
            wr_mem[base+low_slot] = 1'b1;
        end
    endtask

    function automatic result_t normalize_and_clear(input int vtx);
        result_t r;
        int base;
        longint total;
        longint num;
        longint q;
        base = vtx * SLOTS_PER_VERTEX;
        total = 0;
        r.vertex = vtx[11:0];
        for (int k = 0; k < SLOTS_PER_VERTEX; k++)
        begin
            total += wt_mem[base+k];
            r.dfm[k] = wr_mem[base+k] ? dfm_mem[base+k] : root_dfm;
        end
        for (int k = 0; k < SLOTS_PER_VERTEX; k++)
        begin
            if (total == 0)
                r.wt[k] = (k == 0) ? 16'hFFFF : 16'h0;
            else
            begin
                num = 64'd65535 * wt_mem[base+k] * 1000 + 499 * total;
                q = num / (1000 * total);
                r.wt[k] = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            wt_mem[base+k] = 0;
            wr_mem[base+k] = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        emits_seen = 0;
        pending_emits = 0;
        root_dfm = '0;
        foreach (wt_mem[i])
        begin
            wt_mem[i] = '0;
            wr_mem[i] = 1'b0;
            dfm_mem[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n)
        begin
            if (cfg_we)
                root_dfm = cfg_wdata;
            if (pop && !empty)
            begin
                if (emit_queue.size() == 0)
                begin
                    $error("result for vertex %0d with no emit waiting", out_vertex);
                    fail_count++;
                end
                else
                begin
                    e = emit_queue.pop_front();
                    emits_seen++;
                    check_field("out_vertex", e.vertex, out_vertex);
                    check_field("slot0_deformer", e.dfm[0], slot0_deformer);
                    check_field("slot1_deformer", e.dfm[1], slot1_deformer);
                    check_field("slot2_deformer", e.dfm[2], slot2_deformer);
                    check_field("slot3_deformer", e.dfm[3], slot3_deformer);
                    check_field("slot0_weight", e.wt[0], slot0_weight);
                    check_field("slot1_weight", e.wt[1], slot1_weight);
                    check_field("slot2_weight", e.wt[2], slot2_weight);
                    check_field("slot3_weight", e.wt[3], slot3_weight);
                end
            end
            if (push && !full)
            begin
                if (req_type == REQ_ADD)
                    add_influence(vertex_index, deformer_index, influence_weight);
                else
                    emit_queue.insert(emit_queue.size(), normalize_and_clear(vertex_index));
            end
            pending_emits = emit_queue.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import tkc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        push;
    logic        full;
    logic        req_type;
    logic [11:0] vertex_index;
    logic [15:0] deformer_index;
    logic [15:0] influence_weight;
    logic        empty;
    logic        pop;
    logic [11:0] out_vertex;
    logic [15:0] slot0_deformer, slot1_deformer, slot2_deformer, slot3_deformer;
    logic [15:0] slot0_weight, slot1_weight, slot2_weight, slot3_weight;
    int          fail_count;
    int          pending_emits;
    int          emits_seen;

    // idle odds in percent for sender and receiver
    int          send_idle_pct;
    int          recv_idle_pct;
    int          request_count;

    top_k_skin_weight_compactor dut (.*);

    tkc_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random pop, one nonblocking write per edge
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one request and hold it until accepted. Idle gaps happen before
    // the request goes up, never mid-handshake.
    task automatic send_request(input logic typ, input logic [11:0] vtx,
                                input logic [15:0] dfm, input logic [15:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= typ;
        vertex_index <= vtx;
        deformer_index <= dfm;
        influence_weight <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        request_count++;
    endtask

    // Wait until every emit has come back, then let adds in the queue drain
    // (the queue is 2 deep) before a config write.
    task automatic drain_and_set_root(input logic [15:0] root);
        push <= 1'b0;
        @(posedge clk);
        while (pending_emits != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= root;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly a small vertex pool so that slots fill up and get replaced;
    // weights lean toward ties, zero and full scale.
    function automatic logic [15:0] pick_weight();
        case ($urandom_range(7))
            0: return 16'h0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(4));
            3: return 16'(16'h100 * $urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic [11:0] vtx;
        for (int i = 0; i < n; i++)
        begin
            vtx = ($urandom_range(9) < 8) ? 12'($urandom_range(15)) : 12'($urandom);
            if ($urandom_range(99) < 22)
                send_request(REQ_EMIT, vtx, 16'($urandom), 16'($urandom));
            else
                send_request(REQ_ADD, vtx, 16'($urandom), pick_weight());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        push = 1'b0;
        req_type = REQ_ADD;
        vertex_index = '0;
        deformer_index = '0;
        influence_weight = '0;
        request_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: root at reset value, untouched vertex, extremes
        send_request(REQ_EMIT, 12'd0, 16'hFFFF, 16'hFFFF);
        send_request(REQ_EMIT, 12'd4095, 16'h0, 16'h0);
        drain_and_set_root(16'hFFFF);
        send_request(REQ_EMIT, 12'd4095, 16'h0, 16'h0);
        // full-scale fill, then a loser and a strict winner on the lowest slot
        send_request(REQ_ADD, 12'd4095, 16'hFFFF, 16'hFFFF);
        send_request(REQ_ADD, 12'd4095, 16'h0001, 16'h0001);
        send_request(REQ_ADD, 12'd4095, 16'h0002, 16'h0001);
        send_request(REQ_ADD, 12'd4095, 16'h0003, 16'h8000);
        send_request(REQ_ADD, 12'd4095, 16'h0004, 16'h0001);
        send_request(REQ_ADD, 12'd4095, 16'h0005, 16'h0002);
        send_request(REQ_EMIT, 12'd4095, 16'h0, 16'h0);
        // zero-weight add marks a slot written with weight zero
        send_request(REQ_ADD, 12'd7, 16'hABCD, 16'h0);
        send_request(REQ_EMIT, 12'd7, 16'h0, 16'h0);
        // one slot only, and four equal weights (rounding of 65535/4)
        send_request(REQ_ADD, 12'd8, 16'h1234, 16'h0001);
        send_request(REQ_EMIT, 12'd8, 16'h0, 16'h0);
        for (int k = 0; k < 4; k++)
            send_request(REQ_ADD, 12'd9, 16'(k), 16'hFFFF);
        send_request(REQ_ADD, 12'd9, 16'h9999, 16'hFFFF);
        send_request(REQ_EMIT, 12'd9, 16'h0, 16'h0);
        send_request(REQ_EMIT, 12'd9, 16'h0, 16'h0);
        drain_and_set_root(16'h0);
        send_request(REQ_ADD, 12'd0, 16'h0, 16'h5555);
        send_request(REQ_EMIT, 12'd0, 16'h0, 16'h0);

        send_idle_pct = 6;
        recv_idle_pct = 48;
        random_phase(310);
        drain_and_set_root(16'($urandom));
        send_idle_pct = 48;
        recv_idle_pct = 6;
        random_phase(310);
        drain_and_set_root(16'h8001);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(310);

        push <= 1'b0;
        while (pending_emits != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("ran %0d requests, %0d emit results checked, root deformer values 0..FFFF",
                 request_count, emits_seen);
        if (fail_count == 0)
            $display("top_k_skin_weight_compactor regression: pass");
        else
            $display("top_k_skin_weight_compactor regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("top_k_skin_weight_compactor regression: fail");
        $finish;
    end

endmodule
